@@ design/coap_tcp_message_parser_core_macros.svh @@
// Assertion macros shared by the parser modules
`ifndef COAP_TCP_MESSAGE_PARSER_CORE_MACROS_SVH
`define COAP_TCP_MESSAGE_PARSER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CTP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ctp_pkg.sv @@
`timescale 1ns / 1ps
package ctp_pkg;

  localparam int unsigned MaxRes = 3;
  localparam logic [3:0] MaxTokenLengthReset = 4'd8;

  typedef enum logic [9:0] {
    PH_LEN     = 10'b0000000001,
    PH_EXT     = 10'b0000000010,
    PH_CODE    = 10'b0000000100,
    PH_TOKEN   = 10'b0000001000,
    PH_OPT     = 10'b0000010000,
    PH_DEXT    = 10'b0000100000,
    PH_LEXT    = 10'b0001000000,
    PH_VALUE   = 10'b0010000000,
    PH_PAYLOAD = 10'b0100000000,
    PH_SKIP    = 10'b1000000000
  } phase_t;

  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_TOKEN   = 3'd1,
    EV_OPTBYTE = 3'd2,
    EV_OPTDONE = 3'd3,
    EV_PAYLOAD = 3'd4,
    EV_END     = 3'd5,
    EV_ERROR   = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_REQ    = 2'd1,
    ST_BAD_OPTION = 2'd2,
    ST_NO_PROXY   = 2'd3
  } status_t;

  // declared from the high bits down: event_res lands in the low bits
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] option_value;
    logic [16:0] opt_len;
    logic [15:0] opt_num;
    logic [32:0] body_length;
    logic [3:0]  token_length;
    logic [7:0]  message_code;
    status_t     status;
    event_t      event_res;
  } result_t;

  // results of one byte, in order; count is 0..3
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } batch_t;

  localparam int unsigned ResultBits = $bits(result_t) + 1;
  localparam int unsigned TdataBits  = ((ResultBits + 7) / 8) * 8;

  function automatic logic [31:0] ext_shift(input logic [2:0] c, input logic [7:0] b);
    logic [31:0] r;
    begin
      case (c)
        3'd1:    r = {24'd0, b};
        3'd2:    r = {16'd0, b, 8'd0};
        3'd3:    r = {8'd0, b, 16'd0};
        3'd4:    r = {b, 24'd0};
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic odd_known(input logic [16:0] n);
    return n == 17'd1 || n == 17'd3 || n == 17'd5 || n == 17'd7 || n == 17'd11 ||
           n == 17'd15 || n == 17'd17 || n == 17'd23 || n == 17'd27;
  endfunction

endpackage

@@ design/ctp_parse.sv @@
`timescale 1ns / 1ps
`include "coap_tcp_message_parser_core_macros.svh"
module ctp_parse import ctp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [3:0]   max_token_length,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  output batch_t       batch
);

  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  extension_count, extension_count_next;
  logic [32:0] declared_length, declared_length_next;
  logic [32:0] body_bytes_seen, body_bytes_seen_next;
  logic [3:0]  token_remaining, token_remaining_next;
  logic [16:0] number_accum, number_accum_next;
  logic [16:0] delta_work, delta_work_next;
  logic [16:0] length_work, length_work_next;
  logic [16:0] value_remaining, value_remaining_next;
  logic [31:0] value_accum, value_accum_next;
  logic [1:0]  error_seen, error_seen_next;
  logic [7:0]  code_held, code_held_next;

  result_t     res [MaxRes];
  logic [1:0]  npend;
  logic        failed;

  function automatic result_t blank(input event_t ev);
    result_t r;
    begin
      r = '0;
      r.event_res = ev;
      return r;
    end
  endfunction

  always_comb begin
    logic        done;
    logic [17:0] n;
    logic [31:0] es;
    logic [16:0] dw;
    logic [16:0] lw;
    logic [16:0] lsum;
    logic        do_len;
    logic        do_fin;
    result_t     ro;
    parse_phase_next     = parse_phase;
    extension_count_next = extension_count;
    declared_length_next = declared_length;
    body_bytes_seen_next = body_bytes_seen;
    token_remaining_next = token_remaining;
    number_accum_next    = number_accum;
    delta_work_next      = delta_work;
    length_work_next     = length_work;
    value_remaining_next = value_remaining;
    value_accum_next     = value_accum;
    error_seen_next      = error_seen;
    code_held_next       = code_held;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;
    npend  = 2'd0;
    failed = 1'b0;
    done   = 1'b0;
    n      = '0;
    es     = '0;
    dw     = '0;
    lw     = '0;
    lsum   = '0;
    do_len = 1'b0;
    do_fin = 1'b0;
    ro     = '0;

    case (parse_phase)
      PH_LEN: begin
        token_remaining_next = (in_byte[3:0] > max_token_length) ? max_token_length
                                                                 : in_byte[3:0];
        body_bytes_seen_next = '0;
        number_accum_next    = '0;
        error_seen_next      = ST_OK;
        extension_count_next = 3'd0;
        parse_phase_next     = PH_EXT;
        if (in_byte[7:4] < 4'd13) begin
          declared_length_next = {29'd0, in_byte[7:4]};
          parse_phase_next     = PH_CODE;
        end else if (in_byte[7:4] == 4'd13) begin
          declared_length_next = 33'd13;
          extension_count_next = 3'd1;
        end else if (in_byte[7:4] == 4'd14) begin
          declared_length_next = 33'd269;
          extension_count_next = 3'd2;
        end else begin
          declared_length_next = 33'd65805;
          extension_count_next = 3'd4;
        end
      end
      PH_EXT: begin
        declared_length_next = declared_length +
                               {1'b0, ext_shift(extension_count, in_byte)};
        if (extension_count != 3'd0) extension_count_next = extension_count - 3'd1;
        if (extension_count <= 3'd1) parse_phase_next = PH_CODE;
      end
      PH_CODE: begin
        code_held_next   = in_byte;
        ro               = blank(EV_HEADER);
        ro.message_code  = in_byte;
        ro.token_length  = token_remaining;
        ro.body_length   = declared_length;
        res[0] = ro;
        npend  = 2'd1;
        if (token_remaining != 4'd0) parse_phase_next = PH_TOKEN;
        else if (declared_length == '0) begin
          res[1] = blank(EV_END);
          npend  = 2'd2;
          parse_phase_next = PH_LEN;
        end else parse_phase_next = PH_OPT;
      end
      PH_TOKEN: begin
        ro           = blank(EV_TOKEN);
        ro.data_byte = in_byte;
        res[0] = ro;
        npend  = 2'd1;
        if (token_remaining != 4'd0) token_remaining_next = token_remaining - 4'd1;
        if (token_remaining <= 4'd1) begin
          if (declared_length == '0) begin
            res[1] = blank(EV_END);
            npend  = 2'd2;
            parse_phase_next = PH_LEN;
          end else parse_phase_next = PH_OPT;
        end
      end
      default: begin
        body_bytes_seen_next = body_bytes_seen + 33'd1;
        done = body_bytes_seen_next >= declared_length;
        dw = delta_work;
        lw = length_work;
        case (parse_phase)
          PH_OPT: begin
            if (in_byte[7:4] == 4'hF) begin
              if (done) begin
                ro = blank(EV_ERROR); ro.status = ST_BAD_REQ;
                res[0] = ro; npend = 2'd1; failed = 1'b1;
                error_seen_next = ST_BAD_REQ; parse_phase_next = PH_SKIP;
              end else parse_phase_next = PH_PAYLOAD;
            end else begin
              dw = {13'd0, in_byte[7:4]};
              lw = {13'd0, in_byte[3:0]};
              if (lw == 17'd15) begin
                ro = blank(EV_ERROR); ro.status = ST_BAD_REQ;
                res[0] = ro; npend = 2'd1; failed = 1'b1;
                error_seen_next = ST_BAD_REQ; parse_phase_next = PH_SKIP;
              end else if (dw == 17'd13) begin
                extension_count_next = 3'd1; parse_phase_next = PH_DEXT;
              end else if (dw == 17'd14) begin
                dw = 17'd269; extension_count_next = 3'd2; parse_phase_next = PH_DEXT;
              end else do_len = 1'b1;
            end
          end
          PH_DEXT: begin
            es = ext_shift(extension_count, in_byte);
            dw = delta_work + es[16:0];
            if (extension_count != 3'd0) extension_count_next = extension_count - 3'd1;
            if (extension_count <= 3'd1) do_len = 1'b1;
          end
          PH_LEXT: begin
            es = ext_shift(extension_count, in_byte);
            lw = length_work + es[16:0];
            if (extension_count != 3'd0) extension_count_next = extension_count - 3'd1;
            if (extension_count <= 3'd1) do_fin = 1'b1;
          end
          PH_VALUE: begin
            value_accum_next = {value_accum[23:0], in_byte};
            ro = blank(EV_OPTBYTE);
            ro.opt_num      = number_accum[15:0];
            ro.opt_len      = length_work;
            ro.option_value = value_accum_next;
            ro.data_byte    = in_byte;
            res[0] = ro; npend = 2'd1;
            if (value_remaining != '0) value_remaining_next = value_remaining - 17'd1;
            if (value_remaining <= 17'd1) begin
              ro.event_res = EV_OPTDONE;
              ro.data_byte = 8'd0;
              res[1] = ro; npend = 2'd2;
              parse_phase_next = PH_OPT;
            end
          end
          PH_PAYLOAD: begin
            ro = blank(EV_PAYLOAD); ro.data_byte = in_byte;
            res[0] = ro; npend = 2'd1;
          end
          default: ;
        endcase
        if (do_len) begin
          if (lw == 17'd13) begin
            extension_count_next = 3'd1; parse_phase_next = PH_LEXT;
          end else if (lw == 17'd14) begin
            lw = 17'd269; extension_count_next = 3'd2; parse_phase_next = PH_LEXT;
          end else do_fin = 1'b1;
        end
        delta_work_next  = dw;
        length_work_next = lw;
        if (do_fin) begin
          lsum = lw;
          // one bit of headroom: the sum can pass 17 bits
          n = {1'b0, number_accum} + {1'b0, dw};
          if (n > 18'd65535 || n == 18'd35 || n == 18'd39 ||
              (n[0] && !odd_known(n[16:0]))) begin
            ro = blank(EV_ERROR);
            ro.status = (n == 18'd35 || n == 18'd39) ? ST_NO_PROXY : ST_BAD_OPTION;
            res[0] = ro; npend = 2'd1; failed = 1'b1;
            error_seen_next = ro.status; parse_phase_next = PH_SKIP;
          end else begin
            number_accum_next    = n[16:0];
            value_remaining_next = lsum;
            value_accum_next     = '0;
            if (lsum == '0) begin
              ro = blank(EV_OPTDONE);
              ro.opt_num = n[15:0];
              ro.opt_len = lsum;
              res[0] = ro; npend = 2'd1;
              parse_phase_next = PH_OPT;
            end else parse_phase_next = PH_VALUE;
          end
        end
        if (done) begin
          if (failed || parse_phase_next == PH_SKIP) parse_phase_next = PH_LEN;
          else if (parse_phase_next == PH_OPT || parse_phase_next == PH_PAYLOAD) begin
            res[npend] = blank(EV_END);
            npend = npend + 2'd1;
            parse_phase_next = PH_LEN;
          end else begin
            ro = blank(EV_ERROR); ro.status = ST_BAD_REQ;
            res[npend] = ro; npend = npend + 2'd1;
            error_seen_next = ST_BAD_REQ; parse_phase_next = PH_LEN;
          end
        end
      end
    endcase

    if (in_last && parse_phase_next != PH_LEN) begin
      if (parse_phase_next != PH_SKIP) begin
        ro = blank(EV_ERROR); ro.status = ST_BAD_REQ;
        res[npend] = ro; npend = npend + 2'd1;
        error_seen_next = ST_BAD_REQ;
      end
      parse_phase_next = PH_LEN;
    end
  end

  assign batch.count = in_valid ? npend : 2'd0;
  assign batch.r0 = res[0];
  assign batch.r1 = res[1];
  assign batch.r2 = res[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_LEN;
      extension_count <= '0;
      declared_length <= '0;
      body_bytes_seen <= '0;
      token_remaining <= '0;
      code_held       <= '0;
      number_accum    <= '0;
      delta_work      <= '0;
      length_work     <= '0;
      value_remaining <= '0;
      value_accum     <= '0;
      error_seen      <= '0;
    end else if (in_valid) begin
      parse_phase     <= parse_phase_next;
      extension_count <= extension_count_next;
      declared_length <= declared_length_next;
      body_bytes_seen <= body_bytes_seen_next;
      token_remaining <= token_remaining_next;
      code_held       <= code_held_next;
      number_accum    <= number_accum_next;
      delta_work      <= delta_work_next;
      length_work     <= length_work_next;
      value_remaining <= value_remaining_next;
      value_accum     <= value_accum_next;
      error_seen      <= error_seen_next;
    end
  end

  `CTP_ASSERT_IMPL(a_phase_onehot, clk, rst, 1'b1, $onehot(parse_phase), "phase not one-hot")
  `CTP_ASSERT_NEXT(a_last_to_len, clk, rst, in_valid && in_last, parse_phase == PH_LEN,
                   "last byte did not return to length phase")
  `CTP_ASSERT_IMPL(a_ext_bound, clk, rst, 1'b1, extension_count <= 3'd4,
                   "extension count out of range")

endmodule

@@ design/ctp_out_queue.sv @@
`timescale 1ns / 1ps
`include "coap_tcp_message_parser_core_macros.svh"
module ctp_out_queue import ctp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  batch_t               batch,
  output logic                 space,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TdataBits-1:0] m_tdata
);

  // one batch held; next batch taken as the last result of the held one leaves
  batch_t     held;
  logic [1:0] idx;
  logic [1:0] cnt;
  result_t    cur;
  logic       fin;

  function automatic logic fin_last(input logic [1:0] i, input logic [1:0] c);
    return i + 2'd1 == c;
  endfunction

  always_comb begin
    case (idx)
      2'd0:    cur = held.r0;
      2'd1:    cur = held.r1;
      default: cur = held.r2;
    endcase
  end

  assign m_tvalid = cnt != 2'd0;
  assign fin      = m_tvalid && m_tready && (idx + 2'd1 == cnt);
  assign space    = !m_tvalid || fin;
  assign m_tdata  = {{(TdataBits - ResultBits){1'b0}}, fin_last(idx, cnt), cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (space) begin
      cnt <= batch.count;
      idx <= '0;
    end else if (m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (space) held <= batch;
  end

  `CTP_ASSERT_IMPL(a_idx_range, clk, rst, m_tvalid, idx < cnt, "result index past count")
  `CTP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, $stable(idx) && m_tvalid,
                   "stalled result moved")
  `CTP_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt <= 2'd3, "batch count too large")

endmodule

@@ design/coap_tcp_message_parser_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Contents
// s_axis    in   tdata {last_byte, message_byte}
// m_axis    out  tdata event_res, status, message_code, token_length,
//                body_length, opt_num, opt_len, option_value, data_byte,
//                last_result from the low bit up
// cfg       in   max_token_length write
// One byte is parsed per cycle; the next byte is accepted once the result
// register has drained the previous byte's 0 to 3 results.
// Bytes with no result flow at one per cycle.
// rst is synchronous and returns to the length-nibble phase, token clamp 8.
// A stalled output holds its transaction and stops input acceptance.
module coap_tcp_message_parser_core import ctp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // message_byte[7:0], last_byte[8]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataBits-1:0] m_axis_tdata    // event_res .. last_result
);

  logic [3:0] max_token_length;
  batch_t     batch;
  logic       space;

  always_ff @(posedge clk) begin
    if (rst) max_token_length <= MaxTokenLengthReset;
    else if (cfg_we) max_token_length <= cfg_wdata;
  end

  assign s_axis_tready = space;

  ctp_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .max_token_length (max_token_length),
    .in_valid         (s_axis_tvalid && space),
    .in_byte          (s_axis_tdata[7:0]),
    .in_last          (s_axis_tdata[8]),
    .batch            (batch)
  );

  ctp_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .batch    (batch),
    .space    (space),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ctp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum int {
    W_LEN, W_EXT, W_CODE, W_TOKEN, W_OPT, W_DEXT, W_LEXT, W_VALUE, W_PAYLOAD, W_SKIP
  } walk_t;

  typedef struct {
    event_t      ev;
    status_t     st;
    logic [7:0]  code;
    logic [3:0]  tkl;
    logic [32:0] blen;
    logic [15:0] onum;
    logic [16:0] olen;
    logic [31:0] oval;
    logic [7:0]  data;
    logic        last;
  } parse_event_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } msg_byte_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [3:0] cfg_wdata = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [TdataBits-1:0] m_axis_tdata;

  coap_tcp_message_parser_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),     // message_byte[7:0], last_byte[8]
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)      // event_res .. last_result
  );

  initial begin
    forever #4 clk = ~clk;
  end

  msg_byte_t    pending_bytes[$];
  parse_event_t expected_events[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  rx_hold = 0;
  int unsigned  items_made = 0;
  bit           in_busy = 0;

  // parser state mirror
  logic [3:0]  tok_clamp = MaxTokenLengthReset;
  walk_t       walk = W_LEN;
  int unsigned ext_cnt = 0;
  logic [63:0] decl_len = 0;
  logic [63:0] body_seen = 0;
  int unsigned tok_rem = 0;
  int unsigned num_acc = 0;
  int unsigned dwork = 0;
  int unsigned lwork = 0;
  int unsigned vrem = 0;
  logic [31:0] vacc = 0;
  bit          step_failed;
  parse_event_t step_events[3];
  int          n_events;
  int          cur;

  function automatic logic [31:0] ext_weight(input logic [7:0] b);
    if (ext_cnt == 0 || ext_cnt > 4) return 32'd0;
    return {24'd0, b} << (8 * (ext_cnt - 1));
  endfunction

  task automatic add_event(input event_t ev);
    cur = n_events < 3 ? n_events : 2;
    step_events[cur] = '{ev: ev, st: ST_OK, default: '0};
    if (n_events < 3) n_events++;
  endtask

  task automatic flag_error(input status_t st);
    add_event(EV_ERROR);
    step_events[cur].st = st;
    step_failed = 1;
    walk = W_SKIP;
  endtask

  task automatic add_option_event(input event_t ev, input logic [7:0] b);
    add_event(ev);
    step_events[cur].onum = num_acc[15:0];
    step_events[cur].olen = lwork[16:0];
    step_events[cur].oval = vacc;
    step_events[cur].data = b;
  endtask

  task automatic close_option_header();
    int unsigned n;
    bit known;
    n = num_acc + dwork;
    known = n inside {1, 3, 5, 7, 11, 15, 17, 23, 27};
    if (n > 65535) flag_error(ST_BAD_OPTION);
    else if (n == 35 || n == 39) flag_error(ST_NO_PROXY);
    else if (n[0] && !known) flag_error(ST_BAD_OPTION);
    else begin
      num_acc = n;
      vrem = lwork;
      vacc = 0;
      if (lwork == 0) begin
        add_option_event(EV_OPTDONE, 8'd0);
        walk = W_OPT;
      end else begin
        walk = W_VALUE;
      end
    end
  endtask

  task automatic open_option_length();
    if (lwork == 13) begin
      ext_cnt = 1; walk = W_LEXT;
    end else if (lwork == 14) begin
      lwork = 269; ext_cnt = 2; walk = W_LEXT;
    end else begin
      close_option_header();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    bit done;
    n_events = 0;
    step_failed = 0;
    case (walk)
      W_LEN: begin
        tok_rem = b[3:0] > tok_clamp ? tok_clamp : b[3:0];
        body_seen = 0; num_acc = 0; ext_cnt = 0;
        walk = W_EXT;
        if (b[7:4] < 13) begin
          decl_len = b[7:4]; walk = W_CODE;
        end else if (b[7:4] == 13) begin
          decl_len = 13; ext_cnt = 1;
        end else if (b[7:4] == 14) begin
          decl_len = 269; ext_cnt = 2;
        end else begin
          decl_len = 65805; ext_cnt = 4;
        end
      end
      W_EXT: begin
        decl_len += ext_weight(b);
        if (ext_cnt > 0) ext_cnt--;
        if (ext_cnt == 0) walk = W_CODE;
      end
      W_CODE: begin
        add_event(EV_HEADER);
        step_events[cur].code = b;
        step_events[cur].tkl = tok_rem[3:0];
        step_events[cur].blen = decl_len[32:0];
        if (tok_rem != 0) walk = W_TOKEN;
        else if (decl_len == 0) begin
          add_event(EV_END); walk = W_LEN;
        end else walk = W_OPT;
      end
      W_TOKEN: begin
        add_event(EV_TOKEN);
        step_events[cur].data = b;
        if (tok_rem > 0) tok_rem--;
        if (tok_rem == 0) begin
          if (decl_len == 0) begin
            add_event(EV_END); walk = W_LEN;
          end else walk = W_OPT;
        end
      end
      default: begin
        body_seen++;
        done = body_seen >= decl_len;
        case (walk)
          W_OPT: begin
            if (b[7:4] == 4'hF) begin
              if (done) flag_error(ST_BAD_REQ);
              else walk = W_PAYLOAD;
            end else begin
              dwork = b[7:4];
              lwork = b[3:0];
              if (lwork == 15) flag_error(ST_BAD_REQ);
              else if (dwork == 13) begin
                ext_cnt = 1; walk = W_DEXT;
              end else if (dwork == 14) begin
                dwork = 269; ext_cnt = 2; walk = W_DEXT;
              end else open_option_length();
            end
          end
          W_DEXT: begin
            dwork += ext_weight(b);
            if (ext_cnt > 0) ext_cnt--;
            if (ext_cnt == 0) open_option_length();
          end
          W_LEXT: begin
            lwork += ext_weight(b);
            if (ext_cnt > 0) ext_cnt--;
            if (ext_cnt == 0) close_option_header();
          end
          W_VALUE: begin
            vacc = {vacc[23:0], b};
            add_option_event(EV_OPTBYTE, b);
            if (vrem > 0) vrem--;
            if (vrem == 0) begin
              add_option_event(EV_OPTDONE, 8'd0);
              walk = W_OPT;
            end
          end
          W_PAYLOAD: begin
            add_event(EV_PAYLOAD);
            step_events[cur].data = b;
          end
          default: ;
        endcase
        if (done) begin
          if (step_failed || walk == W_SKIP) walk = W_LEN;
          else if (walk == W_OPT || walk == W_PAYLOAD) begin
            add_event(EV_END); walk = W_LEN;
          end else begin
            flag_error(ST_BAD_REQ); walk = W_LEN;
          end
        end
      end
    endcase
    if (last && walk != W_LEN) begin
      if (walk != W_SKIP) flag_error(ST_BAD_REQ);
      walk = W_LEN;
    end
    for (int k = 0; k < n_events; k++) begin
      step_events[k].last = (k == n_events - 1);
      expected_events.push_back(step_events[k]);
    end
  endtask

  // input side: new byte offered at the falling edge, taken at the rising edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      parse_byte(s_axis_tdata[7:0], s_axis_tdata[8]);
      in_busy = 0;
    end
  end

  always @(negedge clk) begin
    if (!rst && !in_busy) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        msg_byte_t m;
        m = pending_bytes.pop_front();
        s_axis_tdata <= {7'd0, m.last, m.b};
        s_axis_tvalid <= 1;
        in_busy = 1;
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual %0h", $time,
                 m_axis_tdata);
      end else begin
        parse_event_t e;
        e = expected_events.pop_front();
        check_field("event_res", e.ev, m_axis_tdata[2:0]);
        check_field("status", e.st, m_axis_tdata[4:3]);
        check_field("message_code", e.code, m_axis_tdata[12:5]);
        check_field("token_length", e.tkl, m_axis_tdata[16:13]);
        check_field("body_length", e.blen, m_axis_tdata[49:17]);
        check_field("opt_num", e.onum, m_axis_tdata[65:50]);
        check_field("opt_len", e.olen, m_axis_tdata[82:66]);
        check_field("option_value", e.oval, m_axis_tdata[114:83]);
        check_field("data_byte", e.data, m_axis_tdata[122:115]);
        check_field("last_result", e.last, m_axis_tdata[123]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic last = 0);
    pending_bytes.push_back('{b: b, last: last});
    items_made++;
  endtask

  task automatic put_ext(input int unsigned v, input int unsigned nbytes);
    for (int i = nbytes - 1; i >= 0; i--) put(8'(v >> (8 * i)));
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || in_busy || expected_events.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_clamp(input logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    tok_clamp = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic int unsigned nib_of(input int unsigned v);
    return v < 13 ? v : (v < 269 ? 13 : 14);
  endfunction

  function automatic int unsigned ext_bytes(input int unsigned v);
    return v < 13 ? 0 : (v < 269 ? 1 : 2);
  endfunction

  function automatic int unsigned ext_val(input int unsigned v);
    return v < 13 ? 0 : (v < 269 ? v - 13 : v - 269);
  endfunction

  task automatic random_message();
    logic [7:0] body[$];
    int unsigned good_nums[] = '{1, 3, 4, 5, 7, 8, 11, 12, 14, 15, 17, 20, 23, 27, 28,
                                 60, 258, 1000, 2048, 65000};
    int unsigned bad_nums[] = '{9, 35, 39, 41, 2049};
    int unsigned tkl, ntok, nopt, num, n, d, len, blen, cut, total;
    msg_byte_t msg[$];
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    tkl = $urandom_range(15);
    ntok = tkl > tok_clamp ? tok_clamp : tkl;
    nopt = $urandom_range(4);
    num = 0;
    for (int i = 0; i < nopt; i++) begin
      if ($urandom_range(19) == 0) n = bad_nums[$urandom_range(bad_nums.size() - 1)];
      else n = good_nums[$urandom_range(good_nums.size() - 1)];
      if (n < num) n = num;
      d = n - num;
      len = ($urandom_range(15) == 0) ? $urandom_range(13, 300) : $urandom_range(6);
      body.push_back({4'(nib_of(d)), 4'(nib_of(len))});
      for (int k = ext_bytes(d) - 1; k >= 0; k--)
        body.push_back(8'(ext_val(d) >> (8 * k)));
      for (int k = ext_bytes(len) - 1; k >= 0; k--)
        body.push_back(8'(ext_val(len) >> (8 * k)));
      repeat (len) body.push_back(8'($urandom_range(255)));
      num = n;
    end
    if ($urandom_range(1)) begin
      body.push_back({4'hF, 4'($urandom_range(15))});
      repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(255)));
    end
    blen = body.size();
    msg.push_back('{b: {4'(nib_of(blen)), tkl[3:0]}, last: 0});
    for (int k = ext_bytes(blen) - 1; k >= 0; k--)
      msg.push_back('{b: 8'(ext_val(blen) >> (8 * k)), last: 0});
    msg.push_back('{b: 8'($urandom_range(255)), last: 0});
    repeat (ntok) msg.push_back('{b: 8'($urandom_range(255)), last: 0});
    foreach (body[i]) msg.push_back('{b: body[i], last: 0});
    total = msg.size();
    cut = ($urandom_range(7) == 0) ? $urandom_range(1, total) : total;
    for (int i = 0; i < cut; i++)
      put(msg[i].b, (i == cut - 1) && (cut < total || $urandom_range(1)));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned target;
    target = items_made + count;
    while (items_made < target) random_message();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_clamp(4'd8);
    // minimal message, header then end
    put(8'h00); put(8'h45, 1);
    // two token bytes, one single-byte option
    put(8'h22); put(8'h02); put(8'h11); put(8'h22); put(8'hB1); put(8'hAB, 1);
    // payload marker as the final body byte
    put(8'h10); put(8'h44); put(8'hFF, 1);
    // reserved option length nibble
    put(8'h10); put(8'h44); put(8'h0F, 1);
    // Proxy-Uri through a one-byte delta extension
    put(8'h20); put(8'h01); put(8'hD0); put(8'h16, 1);
    // option number past 16 bits
    put(8'h30); put(8'h01); put(8'hE0); put(8'hFF); put(8'hFF, 1);
    // truncated message
    put(8'h50); put(8'h01); put(8'h11); put(8'h22, 1);
    // four-byte length extension, cut short
    put(8'hF5); put_ext(32'hFFFF_FFFF, 4); put(8'h02); put(8'hA5); put(8'h5A, 1);
    random_phase(40);
    drain();

    write_clamp(4'd0);
    send_idle_pct = 49;
    // token nibble above the clamp
    put(8'h0F); put(8'h01, 1);
    random_phase(40);
    drain();

    write_clamp(4'd15);
    send_idle_pct = 0;
    rx_stall_pct = 49;
    put(8'h1F); put(8'h01);
    repeat (15) put(8'($urandom_range(255)));
    put(8'hC0, 1);
    random_phase(40);
    drain();

    write_clamp(4'd5);
    send_idle_pct = 17;
    rx_stall_pct = 17;
    random_phase(40);
    drain();

    write_clamp(4'd8);
    send_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 400;
    random_phase(40);
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/ctp_pkg.sv
design/ctp_parse.sv
design/ctp_out_queue.sv
design/coap_tcp_message_parser_core.sv
test/testbench.sv
